>>> sv/bms_pkg.sv
// Package for the bracket match scorer: payload structs, controller/datapath
// command and status structs, status codes and character decode functions.
// No dependencies.
package bms_pkg;

  localparam int CORRUPT_W  = 16;
  localparam int COMPLETE_W = 3;
  localparam int SCORE_W    = 64;
  localparam int DEPTH_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_KINDS  = 4;

  // line_status codes
  localparam logic [1:0] STATUS_BALANCED   = 2'd0;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd1;
  localparam logic [1:0] STATUS_CORRUPT    = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CORRUPT_PAREN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORRUPT_SQUARE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORRUPT_CURLY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORRUPT_ANGLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLETE_PAREN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLETE_SQUARE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLETE_CURLY  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLETE_ANGLE  = 3'd7;

  // bracket kinds
  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;
  localparam logic [1:0] KIND_ANGLE  = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
  localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           line_status;
    logic [CORRUPT_W-1:0] corrupt_points;
    logic [SCORE_W-1:0]   completion_points;
    logic [DEPTH_W-1:0]   open_depth;
  } out_item_t;

  typedef struct packed {
    logic load;         // capture input item, read stack top
    logic exec;         // apply the character to the stack
    logic unwind_step;  // read next stack entry toward the bottom
    logic emit;         // load output register, clear line state
  } cmd_t;

  typedef struct packed {
    logic eol;
    logic need_unwind;
    logic unwind_busy;
    logic acc_pending;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
  } kind_t;

  function automatic kind_t decode_opener(input logic [7:0] ch);
    kind_t k;
    k.hit = 1'b1;
    case (ch)
      CH_OPEN_PAREN:  k.kind = KIND_PAREN;
      CH_OPEN_SQUARE: k.kind = KIND_SQUARE;
      CH_OPEN_CURLY:  k.kind = KIND_CURLY;
      CH_OPEN_ANGLE:  k.kind = KIND_ANGLE;
      default: begin
        k.hit  = 1'b0;
        k.kind = KIND_PAREN;
      end
    endcase
    return k;
  endfunction

  function automatic kind_t decode_closer(input logic [7:0] ch);
    kind_t k;
    k.hit = 1'b1;
    case (ch)
      CH_CLOSE_PAREN:  k.kind = KIND_PAREN;
      CH_CLOSE_SQUARE: k.kind = KIND_SQUARE;
      CH_CLOSE_CURLY:  k.kind = KIND_CURLY;
      CH_CLOSE_ANGLE:  k.kind = KIND_ANGLE;
      default: begin
        k.hit  = 1'b0;
        k.kind = KIND_PAREN;
      end
    endcase
    return k;
  endfunction

endpackage

>>> sv/bms_ctrl.sv
// Controller state machine for the bracket match scorer.
// Depends on bms_pkg (cmd_t, status_t).
module bms_ctrl import bms_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t stat,
  output cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_UNWIND = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!stat.eol) begin
          state_next = S_IDLE;
        end else if (stat.need_unwind) begin
          state_next = S_UNWIND;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_UNWIND: begin
        cmd.unwind_step = stat.unwind_busy;
        // wait for the last read to be folded into the score
        if (!stat.unwind_busy && !stat.acc_pending) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/bms_datapath.sv
// Datapath for the bracket match scorer: closer stack memory, line state,
// completion accumulator, configuration registers and output register.
// Depends on bms_pkg.
module bms_datapath import bms_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              stat,
  input  in_item_t             in_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CORRUPT_W-1:0] cfg_data
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int DW  = (SPW > DEPTH_W) ? SPW : DEPTH_W;
  localparam int PW  = SCORE_W + 3;

  logic [CORRUPT_W-1:0]  cw [NUM_KINDS];
  logic [COMPLETE_W-1:0] kw [NUM_KINDS];

  logic [1:0]    mem [STACK_DEPTH];
  logic [1:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic [7:0]           ch;
  logic                 eol;
  logic [SPW-1:0]       sp;
  logic [SPW-1:0]       sp_next;
  logic                 corrupt;
  logic                 corrupt_next;
  logic                 ovf;
  logic                 ovf_next;
  logic [CORRUPT_W-1:0] fe;
  logic [CORRUPT_W-1:0] fe_next;
  logic [SPW-1:0]       cnt;
  logic                 acc_pending;
  logic [SCORE_W-1:0]   comp;

  logic [SPW-1:0] sp_dec;
  logic [SPW-1:0] cnt_dec;
  kind_t          op;
  kind_t          cl;
  logic [PW-1:0]  prod;
  logic [DW-1:0]  sp_ext;
  out_item_t      result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cw[KIND_PAREN]  <= 16'd3;
      cw[KIND_SQUARE] <= 16'd57;
      cw[KIND_CURLY]  <= 16'd1197;
      cw[KIND_ANGLE]  <= 16'd25137;
      kw[KIND_PAREN]  <= 3'd1;
      kw[KIND_SQUARE] <= 3'd2;
      kw[KIND_CURLY]  <= 3'd3;
      kw[KIND_ANGLE]  <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CORRUPT_PAREN:   cw[KIND_PAREN]  <= cfg_data;
        REG_CORRUPT_SQUARE:  cw[KIND_SQUARE] <= cfg_data;
        REG_CORRUPT_CURLY:   cw[KIND_CURLY]  <= cfg_data;
        REG_CORRUPT_ANGLE:   cw[KIND_ANGLE]  <= cfg_data;
        REG_COMPLETE_PAREN:  kw[KIND_PAREN]  <= cfg_data[COMPLETE_W-1:0];
        REG_COMPLETE_SQUARE: kw[KIND_SQUARE] <= cfg_data[COMPLETE_W-1:0];
        REG_COMPLETE_CURLY:  kw[KIND_CURLY]  <= cfg_data[COMPLETE_W-1:0];
        REG_COMPLETE_ANGLE:  kw[KIND_ANGLE]  <= cfg_data[COMPLETE_W-1:0];
        default: ;
      endcase
    end
  end

  assign sp_dec  = sp - 1'b1;
  assign cnt_dec = cnt - 1'b1;
  assign op      = decode_opener(ch);
  assign cl      = decode_closer(ch);

  // top of stack on load, next entry down while unwinding
  assign rd_addr = cmd.unwind_step ? cnt_dec[AW-1:0] : sp_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[sp[AW-1:0]] <= op.kind;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    sp_next      = sp;
    corrupt_next = corrupt;
    ovf_next     = ovf;
    fe_next      = fe;
    mem_we       = 1'b0;
    if (!corrupt && !ovf) begin
      if (op.hit) begin
        if (sp == SPW'(STACK_DEPTH)) begin
          ovf_next = 1'b1;
        end else begin
          mem_we  = cmd.exec;
          sp_next = sp + 1'b1;
        end
      end else if (cl.hit) begin
        if ((sp != '0) && (rd_data == cl.kind)) begin
          sp_next = sp_dec;
        end else begin
          corrupt_next = 1'b1;
          fe_next      = cw[cl.kind];
        end
      end
    end
  end

  // comp*5 + digit, saturate when it leaves 64 bits
  assign prod = (PW'(comp) << 2) + PW'(comp) + PW'(kw[rd_data]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch  <= in_data.char_code;
      eol <= in_data.end_of_line;
    end
    if (cmd.exec) begin
      comp <= '0;
    end else if (acc_pending) begin
      comp <= (prod[PW-1:SCORE_W] != '0) ? {SCORE_W{1'b1}} : prod[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp          <= '0;
      corrupt     <= 1'b0;
      ovf         <= 1'b0;
      fe          <= '0;
      cnt         <= '0;
      acc_pending <= 1'b0;
    end else begin
      acc_pending <= cmd.unwind_step;
      if (cmd.exec) begin
        sp      <= sp_next;
        corrupt <= corrupt_next;
        ovf     <= ovf_next;
        fe      <= fe_next;
        cnt     <= sp_next;
      end else if (cmd.unwind_step) begin
        cnt <= cnt_dec;
      end else if (cmd.emit) begin
        sp      <= '0;
        corrupt <= 1'b0;
        ovf     <= 1'b0;
        fe      <= '0;
      end
    end
  end

  assign sp_ext = DW'(sp);

  always_comb begin
    result                   = '0;
    result.open_depth        = (sp_ext > DW'(127)) ? 7'd127 : sp_ext[DEPTH_W-1:0];
    if (ovf) begin
      result.line_status     = STATUS_OVERFLOW;
    end else if (corrupt) begin
      result.line_status     = STATUS_CORRUPT;
      result.corrupt_points  = fe;
    end else if (sp == '0) begin
      result.line_status     = STATUS_BALANCED;
    end else begin
      result.line_status       = STATUS_INCOMPLETE;
      result.completion_points = comp;
    end
  end

  // output register: free when empty or being taken this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= result;
    end
  end

  assign stat.eol         = eol;
  assign stat.need_unwind = !ovf_next && !corrupt_next && (sp_next != '0);
  assign stat.unwind_busy = (cnt != '0);
  assign stat.acc_pending = acc_pending;
  assign stat.out_free    = !out_valid || !out_stall;

endmodule

>>> sv/bracket_match_scorer_top.sv
// Top level of the bracket match scorer: controller plus datapath.
// Depends on bms_pkg, bms_ctrl, bms_datapath.
//
//   Channel  Signals                          Moves
//   input    in_valid, in_stall, in_data      one character and end-of-line flag
//   output   out_valid, out_stall, out_data   one line result
//   config   cfg_we, cfg_index, cfg_data      one weight register write
//
// Each character is first captured, with the stack top read from the stack
// memory, and then pushed, popped or used to flag the line.
// At line end an incomplete line unwinds its stack one entry a cycle through
// the single memory read port; the output register is then loaded, once any
// previous result still stalled there has been taken.
// Reset is synchronous; the stack memory needs no clearing pass.
module bracket_match_scorer_top import bms_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CORRUPT_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t stat;

  bms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bms_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

>>> sim/bms_line_checker.sv
`timescale 1ns / 1ps
// Line result checker for the bracket match scorer: follows config writes and
// character transfers, predicts each line result and compares the output channel.
// Depends on bms_pkg.
module bms_line_checker import bms_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CORRUPT_W-1:0] cfg_data,
  output int                   error_count,
  output int                   lines_pending
);

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  logic [CORRUPT_W-1:0]  corrupt_wt  [NUM_KINDS];
  logic [COMPLETE_W-1:0] complete_wt [NUM_KINDS];

  logic [1:0]           closer_kinds [STACK_DEPTH];
  int                   depth;
  bit                   corrupt;
  bit                   overflow;
  logic [CORRUPT_W-1:0] first_pts;

  out_item_t line_scores[$];

  task automatic clear_line();
    depth     = 0;
    corrupt   = 1'b0;
    overflow  = 1'b0;
    first_pts = '0;
  endtask

  task automatic score_char(input in_item_t item);
    logic [1:0]         kind;
    bit                 is_open;
    bit                 is_close;
    out_item_t          res;
    logic [SCORE_W-1:0] acc;
    logic [SCORE_W-1:0] w;
    is_open  = 1'b0;
    is_close = 1'b0;
    kind     = KIND_PAREN;
    case (item.char_code)
      CH_OPEN_PAREN:   begin is_open  = 1'b1; kind = KIND_PAREN;  end
      CH_OPEN_SQUARE:  begin is_open  = 1'b1; kind = KIND_SQUARE; end
      CH_OPEN_CURLY:   begin is_open  = 1'b1; kind = KIND_CURLY;  end
      CH_OPEN_ANGLE:   begin is_open  = 1'b1; kind = KIND_ANGLE;  end
      CH_CLOSE_PAREN:  begin is_close = 1'b1; kind = KIND_PAREN;  end
      CH_CLOSE_SQUARE: begin is_close = 1'b1; kind = KIND_SQUARE; end
      CH_CLOSE_CURLY:  begin is_close = 1'b1; kind = KIND_CURLY;  end
      CH_CLOSE_ANGLE:  begin is_close = 1'b1; kind = KIND_ANGLE;  end
      default: ;
    endcase

    // a corrupt or overflowed line ignores the rest of its characters
    if (!corrupt && !overflow) begin
      if (is_open) begin
        if (depth < STACK_DEPTH) begin
          closer_kinds[depth] = kind;
          depth++;
        end else begin
          overflow = 1'b1;
        end
      end else if (is_close) begin
        if (depth > 0 && closer_kinds[depth-1] == kind) begin
          depth--;
        end else begin
          corrupt   = 1'b1;
          first_pts = corrupt_wt[kind];
        end
      end
    end

    if (item.end_of_line) begin
      res = '0;
      res.open_depth = DEPTH_W'(depth > 127 ? 127 : depth);
      if (overflow) begin
        res.line_status = STATUS_OVERFLOW;
      end else if (corrupt) begin
        res.line_status    = STATUS_CORRUPT;
        res.corrupt_points = first_pts;
      end else if (depth == 0) begin
        res.line_status = STATUS_BALANCED;
      end else begin
        // unwind from the top, base 5, saturating
        acc = '0;
        for (int i = depth - 1; i >= 0; i--) begin
          w = SCORE_W'(complete_wt[closer_kinds[i]]);
          if (acc > (SCORE_MAX - w) / 5) acc = SCORE_MAX;
          else acc = acc * 5 + w;
        end
        res.line_status       = STATUS_INCOMPLETE;
        res.completion_points = acc;
      end
      line_scores.insert(line_scores.size(), res);
      clear_line();
    end
  endtask

  task automatic check_line(input out_item_t got);
    out_item_t exp;
    if (line_scores.size() == 0) begin
      $error("line result with no line pending: status %0d", got.line_status);
      error_count++;
    end else begin
      exp = line_scores.pop_front();
      if (got.line_status !== exp.line_status) begin
        $error("line_status: expected %0d, got %0d", exp.line_status, got.line_status);
        error_count++;
      end
      if (got.corrupt_points !== exp.corrupt_points) begin
        $error("corrupt_points: expected %0d, got %0d",
               exp.corrupt_points, got.corrupt_points);
        error_count++;
      end
      if (got.completion_points !== exp.completion_points) begin
        $error("completion_points: expected %0d, got %0d",
               exp.completion_points, got.completion_points);
        error_count++;
      end
      if (got.open_depth !== exp.open_depth) begin
        $error("open_depth: expected %0d, got %0d", exp.open_depth, got.open_depth);
        error_count++;
      end
    end
  endtask

  initial error_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      corrupt_wt[KIND_PAREN]   = 16'd3;
      corrupt_wt[KIND_SQUARE]  = 16'd57;
      corrupt_wt[KIND_CURLY]   = 16'd1197;
      corrupt_wt[KIND_ANGLE]   = 16'd25137;
      complete_wt[KIND_PAREN]  = 3'd1;
      complete_wt[KIND_SQUARE] = 3'd2;
      complete_wt[KIND_CURLY]  = 3'd3;
      complete_wt[KIND_ANGLE]  = 3'd4;
      clear_line();
      line_scores.delete();
    end else begin
      if (out_valid && !out_stall) check_line(out_data);
      if (in_valid && !in_stall) score_char(in_data);
      if (cfg_we) begin
        case (cfg_index)
          REG_CORRUPT_PAREN:   corrupt_wt[KIND_PAREN]   = cfg_data;
          REG_CORRUPT_SQUARE:  corrupt_wt[KIND_SQUARE]  = cfg_data;
          REG_CORRUPT_CURLY:   corrupt_wt[KIND_CURLY]   = cfg_data;
          REG_CORRUPT_ANGLE:   corrupt_wt[KIND_ANGLE]   = cfg_data;
          REG_COMPLETE_PAREN:  complete_wt[KIND_PAREN]  = cfg_data[COMPLETE_W-1:0];
          REG_COMPLETE_SQUARE: complete_wt[KIND_SQUARE] = cfg_data[COMPLETE_W-1:0];
          REG_COMPLETE_CURLY:  complete_wt[KIND_CURLY]  = cfg_data[COMPLETE_W-1:0];
          REG_COMPLETE_ANGLE:  complete_wt[KIND_ANGLE]  = cfg_data[COMPLETE_W-1:0];
          default: ;
        endcase
      end
    end
    lines_pending <= line_scores.size();
  end

endmodule

>>> sim/bracket_match_scorer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the bracket match scorer: clock, reset, line stimulus,
// weight register phases and the verdict. Depends on bms_pkg and bms_line_checker.
module bracket_match_scorer_top_tb;
  import bms_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int ITEM_TARGET = 1750;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 100;
  localparam int CYCLE_LIMIT = 1000000;

  typedef logic [7:0] char_q_t[$];

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CORRUPT_W-1:0] cfg_data;

  int error_count;
  int lines_pending;
  int chars_sent;
  int cycle_count;
  bit quiet_send;
  bit long_hold;

  bracket_match_scorer_top #(.STACK_DEPTH(STACK_DEPTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bms_line_checker #(.STACK_DEPTH(STACK_DEPTH)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .lines_pending (lines_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: short random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int stall_left;
    int hold_cnt;
    int r;
    bit quiet_recv;
    stall_left = 0;
    hold_cnt   = 0;
    quiet_recv = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) quiet_recv = !quiet_recv;
      if (long_hold) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) begin
          long_hold = 1'b0;
          hold_cnt  = 0;
        end
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        r = $urandom_range(0, 99);
        if (quiet_recv || r < 70) stall_left = 0;
        else if (r < 95) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(8, 40);
      end
    end
  end

  function automatic logic [7:0] opener_of(input logic [1:0] kind);
    case (kind)
      KIND_PAREN:  return CH_OPEN_PAREN;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      KIND_CURLY:  return CH_OPEN_CURLY;
      default:     return CH_OPEN_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(input logic [1:0] kind);
    case (kind)
      KIND_PAREN:  return CH_CLOSE_PAREN;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      KIND_CURLY:  return CH_CLOSE_CURLY;
      default:     return CH_CLOSE_ANGLE;
    endcase
  endfunction

  task automatic push_char(input logic [7:0] ch, input bit eol);
    in_item_t item;
    int       gap;
    int       r;
    item.char_code   = ch;
    item.end_of_line = eol;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    chars_sent++;
    r = $urandom_range(0, 99);
    if (quiet_send || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_line(input char_q_t line);
    quiet_send = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < line.size(); i++) push_char(line[i], i == line.size() - 1);
  endtask

  // Mostly well-formed bracket nesting with noise and wrong closers mixed in
  task automatic random_line();
    char_q_t    line;
    logic [1:0] open_kinds[$];
    logic [1:0] k;
    int         len;
    int         open_pct;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      len = $urandom_range(1, 6);
      repeat (len) line.insert(line.size(), 8'($urandom_range(0, 255)));
    end else begin
      if (r < 13) begin
        len      = $urandom_range(25, 70);
        open_pct = 85;
      end else begin
        len      = $urandom_range(1, 12);
        open_pct = 40;
      end
      repeat (len) begin
        r = $urandom_range(0, 99);
        k = 2'($urandom_range(0, 3));
        if (r < open_pct || (r < 80 && open_kinds.size() == 0)) begin
          open_kinds.insert(open_kinds.size(), k);
          line.insert(line.size(), opener_of(k));
        end else if (r < 80) begin
          line.insert(line.size(), closer_of(open_kinds.pop_back()));
        end else if (r < 92) begin
          line.insert(line.size(), 8'($urandom_range(0, 255)));
        end else begin
          if (open_kinds.size() > 0 && open_kinds[$] == k) void'(open_kinds.pop_back());
          line.insert(line.size(), closer_of(k));
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        while (open_kinds.size() > 0) begin
          line.insert(line.size(), closer_of(open_kinds.pop_back()));
        end
      end
    end
    send_line(line);
  endtask

  // Full stack, overflow, and a corrupt line deep in the stack
  task automatic deep_lines();
    char_q_t    line;
    logic [1:0] k;
    int         n;
    for (int pass = 0; pass < 3; pass++) begin
      line.delete();
      n = (pass == 0) ? STACK_DEPTH : (pass == 1) ? STACK_DEPTH + 2 : 30;
      k = KIND_PAREN;
      repeat (n) begin
        k = 2'($urandom_range(0, 3));
        line.insert(line.size(), opener_of(k));
      end
      if (pass == 2) line.insert(line.size(), closer_of(k + 2'd1));
      send_line(line);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (lines_pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CORRUPT_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // phase 1: all zero, phase 2: all ones (completion digits masked to 7), else random
  function automatic logic [CORRUPT_W-1:0] weight_for(input int phase);
    if (phase == 1) return '0;
    if (phase == 2) return '1;
    return CORRUPT_W'($urandom_range(0, 65535));
  endfunction

  task automatic write_weights(input int phase);
    write_reg(REG_CORRUPT_PAREN,   weight_for(phase));
    write_reg(REG_CORRUPT_SQUARE,  weight_for(phase));
    write_reg(REG_CORRUPT_CURLY,   weight_for(phase));
    write_reg(REG_CORRUPT_ANGLE,   weight_for(phase));
    write_reg(REG_COMPLETE_PAREN,  weight_for(phase));
    write_reg(REG_COMPLETE_SQUARE, weight_for(phase));
    write_reg(REG_COMPLETE_CURLY,  weight_for(phase));
    write_reg(REG_COMPLETE_ANGLE,  weight_for(phase));
    cfg_we <= 1'b0;
  endtask

  initial begin
    chars_sent = 0;
    quiet_send = 1'b0;
    long_hold  = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_CORRUPT_PAREN;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset weights: empty line, each closer kind going wrong, ignored tails
    send_line('{8'h00});
    send_line('{CH_OPEN_PAREN, CH_CLOSE_PAREN});
    send_line('{CH_OPEN_SQUARE, CH_OPEN_CURLY, CH_OPEN_ANGLE});
    send_line('{CH_CLOSE_PAREN});
    send_line('{CH_OPEN_PAREN, CH_CLOSE_SQUARE});
    send_line('{CH_OPEN_SQUARE, CH_CLOSE_CURLY});
    send_line('{CH_OPEN_CURLY, CH_CLOSE_ANGLE});
    send_line('{CH_OPEN_ANGLE, CH_CLOSE_PAREN});
    send_line('{CH_OPEN_PAREN, CH_CLOSE_SQUARE, CH_OPEN_PAREN, CH_OPEN_PAREN});
    send_line('{CH_OPEN_ANGLE, CH_CLOSE_ANGLE});
    send_line('{8'hFF});
    send_line('{8'h61, CH_OPEN_PAREN, 8'h7A});

    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        drain();
        write_weights(phase);
      end
      if (phase == 0 || phase == 2) deep_lines();
      if (phase == 1) long_hold = 1'b1;
      while (chars_sent < (phase + 1) * ITEM_TARGET / 4) begin
        random_line();
        // late in the last phase, wait out every pending result after each line
        if (phase == 3 && chars_sent > 7 * ITEM_TARGET / 8 && lines_pending > 0) begin
          drain();
          @(posedge clk);
        end
      end
    end
    drain();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
